/* design/rci_pkg.sv */
// shared types and constants for the ray versus cylinder intersector
`default_nettype none
package rci_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int NORM_W    = 18;
   localparam int RAD_W     = 31;
   localparam int CSR_IDX_W = 3;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_RADIUS   = 3'd3,
      CSR_HEIGHT   = 3'd4
   } csr_idx_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [NORM_W-1:0]  norm_type;

endpackage
`default_nettype wire

/* design/rci_sqrt.sv */
// pipelined integer square root, one result bit per stage
`default_nettype none
module rci_sqrt (
   input  wire logic        clock,
   input  wire logic [63:0] radicand,
   output logic [31:0]      root
);
   import rci_pkg::*;

   localparam int STAGES = 32;

   logic [63:0] rem_ff  [0:STAGES];
   logic [31:0] res_ff  [0:STAGES];

   always_comb begin
      rem_ff[0] = radicand;
      res_ff[0] = '0;
   end

   // restoring square root, one bit per stage
   for (genvar gi = 0; gi < STAGES; gi++) begin : g_stage
      logic [63:0] trial_in;
      logic [63:0] rem_in;
      logic [31:0] res_in;
      logic [63:0] rem_q_ff;
      logic [31:0] res_q_ff;
      localparam int BITPOS = STAGES - 1 - gi;
      always_comb begin
         trial_in = ({32'd0, res_ff[gi]} << (BITPOS + 1)) | (64'd1 << (2 * BITPOS));
         if (rem_ff[gi] >= trial_in) begin
            rem_in = rem_ff[gi] - trial_in;
            res_in = res_ff[gi] | (32'd1 << BITPOS);
         end else begin
            rem_in = rem_ff[gi];
            res_in = res_ff[gi];
         end
      end
      always_ff @(posedge clock) begin
         rem_q_ff <= rem_in;
         res_q_ff <= res_in;
      end
      always_comb begin
         rem_ff[gi+1] = rem_q_ff;
         res_ff[gi+1] = res_q_ff;
      end
   end

   assign root = res_ff[STAGES];
endmodule
`default_nettype wire

/* design/rci_div.sv */
// pipelined signed divider, quotient rounded toward zero, one bit per stage
`default_nettype none
module rci_div (
   input  wire logic               clock,
   input  wire logic signed [63:0] dividend,
   input  wire logic [31:0]        divisor,
   output logic signed [63:0]      quotient
);
   import rci_pkg::*;

   localparam int STAGES = 64;

   logic [63:0] num_ff  [0:STAGES];
   logic [63:0] rem_ff  [0:STAGES];
   logic [31:0] den_ff  [0:STAGES];
   logic        neg_ff  [0:STAGES];

   always_comb begin
      num_ff[0] = dividend[63] ? 64'(-dividend) : 64'(dividend);
      rem_ff[0] = '0;
      den_ff[0] = divisor;
      neg_ff[0] = dividend[63];
   end

   // long division on magnitudes, quotient bits shift into num
   for (genvar gi = 0; gi < STAGES; gi++) begin : g_stage
      logic [64:0] shifted;
      logic [63:0] num_in;
      logic [63:0] rem_in;
      logic [63:0] num_q_ff;
      logic [63:0] rem_q_ff;
      logic [31:0] den_q_ff;
      logic        neg_q_ff;
      always_comb begin
         shifted = {rem_ff[gi], num_ff[gi][63]};
         num_in  = {num_ff[gi][62:0], 1'b0};
         if (shifted >= {33'd0, den_ff[gi]}) begin
            rem_in    = 64'(shifted - {33'd0, den_ff[gi]});
            num_in[0] = 1'b1;
         end else begin
            rem_in = shifted[63:0];
         end
      end
      always_ff @(posedge clock) begin
         num_q_ff <= num_in;
         rem_q_ff <= rem_in;
         den_q_ff <= den_ff[gi];
         neg_q_ff <= neg_ff[gi];
      end
      always_comb begin
         num_ff[gi+1] = num_q_ff;
         rem_ff[gi+1] = rem_q_ff;
         den_ff[gi+1] = den_q_ff;
         neg_ff[gi+1] = neg_q_ff;
      end
   end

   assign quotient = neg_ff[STAGES] ? -$signed(num_ff[STAGES]) : $signed(num_ff[STAGES]);
endmodule
`default_nettype wire

/* design/rci_delay.sv */
// fixed-length delay line for side data that rides along a pipeline
`default_nettype none
module rci_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0]      dout
);
   import rci_pkg::*;

   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   // shift register, cleared so valid bits start low
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) tap_ff[i] <= '0;
      end else begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule
`default_nettype wire

/* design/ray_cylinder_intersect.sv */
// top level of the ray versus open cylinder intersector
// Fully pipelined: one request may enter every cycle and busy stays low.
// Each request gives exactly one response; rsp_valid is high for one cycle.
// Most of the pipeline depth comes from the 32 square root stages and two
// 64-stage divider chains in series: the two roots are divided in parallel,
// and then the two normal components are divided in parallel.
// The receiver cannot stall. Configuration must be written only while idle.
`default_nettype none
module ray_cylinder_intersect (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire rci_pkg::coord_type    req_origin_x,
   input  wire rci_pkg::coord_type    req_origin_y,
   input  wire rci_pkg::coord_type    req_origin_z,
   input  wire rci_pkg::coord_type    req_dir_x,
   input  wire rci_pkg::coord_type    req_dir_y,
   input  wire rci_pkg::coord_type    req_dir_z,
   input  wire rci_pkg::coord_type    req_t_min,
   input  wire rci_pkg::coord_type    req_t_max,
   input  wire logic                  csr_write,
   input  wire logic [2:0]            csr_index,
   input  wire logic [31:0]           csr_data,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output rci_pkg::coord_type         rsp_hit_t,
   output rci_pkg::coord_type         rsp_hit_x,
   output rci_pkg::coord_type         rsp_hit_y,
   output rci_pkg::coord_type         rsp_hit_z,
   output rci_pkg::norm_type          rsp_normal_x,
   output rci_pkg::norm_type          rsp_normal_z,
   output logic                       rsp_front_face
);
   import rci_pkg::*;

   localparam int SQRT_LAT = 32;
   localparam int DIV_LAT  = 64;
   localparam int RAY_W    = 8 * COORD_W;

   // configuration registers
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0]        rad_ff, hgt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         cz_ff  <= '0;
         rad_ff <= 31'(64'd1 << FRAC_BITS);
         hgt_ff <= 31'(64'd1 << FRAC_BITS);
      end else if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_CENTER_X: cx_ff  <= csr_data;
            CSR_CENTER_Y: cy_ff  <= csr_data;
            CSR_CENTER_Z: cz_ff  <= csr_data;
            CSR_RADIUS:   rad_ff <= csr_data[30:0];
            CSR_HEIGHT:   hgt_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   function automatic logic signed [63:0] qshr(input logic signed [63:0] v);
      qshr = v >>> FRAC_BITS;
   endfunction

   function automatic logic in32(input logic signed [63:0] v);
      in32 = (v >= -64'sd2147483648) && (v <= 64'sd2147483647);
   endfunction

   // stage 1: register request, offsets
   logic               v1_ff;
   logic signed [31:0] ox1_ff, oy1_ff, oz1_ff, dx1_ff, dy1_ff, dz1_ff, tlo1_ff, thi1_ff;
   logic signed [32:0] ocx1_ff, ocz1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= start;
      ox1_ff  <= req_origin_x;
      oy1_ff  <= req_origin_y;
      oz1_ff  <= req_origin_z;
      dx1_ff  <= req_dir_x;
      dy1_ff  <= req_dir_y;
      dz1_ff  <= req_dir_z;
      tlo1_ff <= req_t_min;
      thi1_ff <= req_t_max;
      ocx1_ff <= 33'(req_origin_x) - 33'(cx_ff);
      ocz1_ff <= 33'(req_origin_z) - 33'(cz_ff);
   end

   // stage 2: products for a, h, c
   logic               v2_ff, bad2_ff;
   logic signed [63:0] pdx2_ff, pdz2_ff, phx2_ff, phz2_ff, pcx2_ff, pcz2_ff, prr2_ff;
   logic [RAY_W-1:0]   ray2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      bad2_ff <= !in32(64'(ocx1_ff)) || !in32(64'(ocz1_ff)) || (rad_ff == '0);
      pdx2_ff <= 64'(dx1_ff) * 64'(dx1_ff);
      pdz2_ff <= 64'(dz1_ff) * 64'(dz1_ff);
      phx2_ff <= 64'($signed(ocx1_ff[31:0])) * 64'(dx1_ff);
      phz2_ff <= 64'($signed(ocz1_ff[31:0])) * 64'(dz1_ff);
      pcx2_ff <= 64'($signed(ocx1_ff[31:0])) * 64'($signed(ocx1_ff[31:0]));
      pcz2_ff <= 64'($signed(ocz1_ff[31:0])) * 64'($signed(ocz1_ff[31:0]));
      prr2_ff <= $signed({33'd0, rad_ff}) * $signed({33'd0, rad_ff});
      ray2_ff <= {ox1_ff, oy1_ff, oz1_ff, dx1_ff, dy1_ff, dz1_ff, tlo1_ff, thi1_ff};
   end

   // stage 3: a, h, c and their range checks
   logic               v3_ff, bad3_ff;
   logic signed [31:0] a3_ff, h3_ff, c3_ff;
   logic [RAY_W-1:0]   ray3_ff;
   logic signed [63:0] a_in, h_in, c_in;

   always_comb begin
      a_in = qshr(pdx2_ff) + qshr(pdz2_ff);
      h_in = qshr(phx2_ff) + qshr(phz2_ff);
      c_in = qshr(pcx2_ff) + qshr(pcz2_ff) - qshr(prr2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      bad3_ff <= bad2_ff || !in32(a_in) || !in32(h_in) || !in32(c_in) || (a_in == 0);
      a3_ff   <= a_in[31:0];
      h3_ff   <= h_in[31:0];
      c3_ff   <= c_in[31:0];
      ray3_ff <= ray2_ff;
   end

   // stage 4: products h*h and a*c for the discriminant
   logic               v4_ff, bad4_ff;
   logic signed [63:0] hh4_ff, ac4_ff;
   logic signed [31:0] a4_ff, h4_ff;
   logic [RAY_W-1:0]   ray4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      bad4_ff <= bad3_ff;
      hh4_ff  <= 64'(h3_ff) * 64'(h3_ff);
      ac4_ff  <= 64'(a3_ff) * 64'(c3_ff);
      a4_ff   <= a3_ff;
      h4_ff   <= h3_ff;
      ray4_ff <= ray3_ff;
   end

   // stage 5: discriminant
   logic               v5_ff, bad5_ff;
   logic signed [64:0] disc5_ff;
   logic signed [31:0] a5_ff, h5_ff;
   logic [RAY_W-1:0]   ray5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
      disc5_ff <= 65'(hh4_ff) - 65'(ac4_ff);
      bad5_ff  <= bad4_ff;
      a5_ff    <= a4_ff;
      h5_ff    <= h4_ff;
      ray5_ff  <= ray4_ff;
   end

   // square root, side data delayed alongside
   logic [31:0] sroot;
   logic [63:0] sqrt_arg;
   assign sqrt_arg = disc5_ff[64] ? 64'd0 : disc5_ff[63:0];

   rci_sqrt u_sqrt (.clock(clock), .radicand(sqrt_arg), .root(sroot));

   localparam int SIDE6_W = 1 + 1 + 32 + 32 + RAY_W;
   logic [SIDE6_W-1:0] side6;
   logic               v6, bad6;
   logic signed [31:0] a6, h6;
   logic [RAY_W-1:0]   ray6;

   rci_delay #(.WIDTH(SIDE6_W), .DEPTH(SQRT_LAT)) u_dly_sqrt (
      .clock(clock), .reset(reset),
      .din({v5_ff, bad5_ff || disc5_ff[64], a5_ff, h5_ff, ray5_ff}),
      .dout(side6));
   assign {v6, bad6, a6, h6, ray6} = side6;

   // stage 7: root numerators
   logic               v7_ff, bad7_ff;
   logic signed [63:0] n1_7_ff, n2_7_ff;
   logic [31:0]        a7_ff;
   logic [RAY_W-1:0]   ray7_ff;

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else v7_ff <= v6;
      bad7_ff <= bad6;
      n1_7_ff <= (-64'(h6) - 64'({32'd0, sroot})) <<< FRAC_BITS;
      n2_7_ff <= (-64'(h6) + 64'({32'd0, sroot})) <<< FRAC_BITS;
      a7_ff   <= a6;
      ray7_ff <= ray6;
   end

   // both roots divided in parallel (a is positive when not flagged bad)
   logic signed [63:0] t1q, t2q;
   rci_div u_div_t1 (.clock(clock), .dividend(n1_7_ff), .divisor(a7_ff), .quotient(t1q));
   rci_div u_div_t2 (.clock(clock), .dividend(n2_7_ff), .divisor(a7_ff), .quotient(t2q));

   localparam int SIDE8_W = 2 + RAY_W;
   logic [SIDE8_W-1:0] side8;
   logic               v8, bad8;
   logic [RAY_W-1:0]   ray8;

   rci_delay #(.WIDTH(SIDE8_W), .DEPTH(DIV_LAT)) u_dly_div (
      .clock(clock), .reset(reset), .din({v7_ff, bad7_ff, ray7_ff}), .dout(side8));
   assign {v8, bad8, ray8} = side8;

   // stage 9: root selection
   logic signed [31:0] tlo8, thi8;
   assign tlo8 = ray8[2*COORD_W-1:COORD_W];
   assign thi8 = ray8[COORD_W-1:0];
   logic ok1, ok2;
   assign ok1 = (t1q >= 64'(tlo8)) && (t1q <= 64'(thi8));
   assign ok2 = (t2q >= 64'(tlo8)) && (t2q <= 64'(thi8));

   logic               v9_ff, bad9_ff;
   logic signed [31:0] t9_ff;
   logic [RAY_W-1:0]   ray9_ff;

   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else v9_ff <= v8;
      bad9_ff <= bad8 || (!ok1 && !ok2);
      t9_ff   <= ok1 ? t1q[31:0] : t2q[31:0];
      ray9_ff <= ray8;
   end

   // stage 10: t times direction
   logic signed [31:0] ox9, oy9, oz9, dx9, dy9, dz9;
   assign {ox9, oy9, oz9, dx9, dy9, dz9} = ray9_ff[RAY_W-1:2*COORD_W];

   logic               v10_ff, bad10_ff;
   logic signed [63:0] px10_ff, py10_ff, pz10_ff;
   logic signed [31:0] t10_ff, ox10_ff, oy10_ff, oz10_ff, dx10_ff, dz10_ff;

   always_ff @(posedge clock) begin
      if (reset) v10_ff <= 1'b0;
      else v10_ff <= v9_ff;
      bad10_ff <= bad9_ff;
      px10_ff  <= 64'(t9_ff) * 64'(dx9);
      py10_ff  <= 64'(t9_ff) * 64'(dy9);
      pz10_ff  <= 64'(t9_ff) * 64'(dz9);
      t10_ff   <= t9_ff;
      ox10_ff  <= ox9;
      oy10_ff  <= oy9;
      oz10_ff  <= oz9;
      dx10_ff  <= dx9;
      dz10_ff  <= dz9;
   end

   // stage 11: hit point
   logic               v11_ff, bad11_ff;
   logic signed [33:0] hx11_ff, hy11_ff, hz11_ff;
   logic signed [31:0] t11_ff, dx11_ff, dz11_ff;
   logic signed [63:0] hy_in;
   assign hy_in = 64'(oy10_ff) + qshr(py10_ff);

   always_ff @(posedge clock) begin
      if (reset) v11_ff <= 1'b0;
      else v11_ff <= v10_ff;
      bad11_ff <= bad10_ff || (hy_in < 64'(cy_ff)) ||
                  (hy_in > 64'(cy_ff) + $signed(64'(hgt_ff)));
      hx11_ff  <= 34'(64'(ox10_ff) + qshr(px10_ff));
      hy11_ff  <= 34'(hy_in);
      hz11_ff  <= 34'(64'(oz10_ff) + qshr(pz10_ff));
      t11_ff   <= t10_ff;
      dx11_ff  <= dx10_ff;
      dz11_ff  <= dz10_ff;
   end

   // stage 12: offsets from axis, clamped, and saturated hit point
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction

   function automatic logic signed [31:0] clampr(input logic signed [34:0] v,
                                                 input logic [30:0] r);
      logic signed [34:0] rr;
      rr = 35'({4'd0, r});
      if (v > rr) clampr = rr[31:0];
      else if (v < -rr) clampr = 32'(-rr);
      else clampr = v[31:0];
   endfunction

   logic               v12_ff, bad12_ff;
   logic signed [31:0] ex12_ff, ez12_ff, t12_ff, hx12_ff, hy12_ff, hz12_ff;
   logic signed [31:0] dx12_ff, dz12_ff;

   always_ff @(posedge clock) begin
      if (reset) v12_ff <= 1'b0;
      else v12_ff <= v11_ff;
      bad12_ff <= bad11_ff;
      ex12_ff  <= clampr(35'(hx11_ff) - 35'(cx_ff), rad_ff);
      ez12_ff  <= clampr(35'(hz11_ff) - 35'(cz_ff), rad_ff);
      t12_ff   <= t11_ff;
      hx12_ff  <= sat32(hx11_ff);
      hy12_ff  <= sat32(hy11_ff);
      hz12_ff  <= sat32(hz11_ff);
      dx12_ff  <= dx11_ff;
      dz12_ff  <= dz11_ff;
   end

   // normal components
   logic signed [63:0] nxq, nzq;
   rci_div u_div_nx (.clock(clock), .dividend(64'(ex12_ff) <<< FRAC_BITS),
                     .divisor({1'b0, rad_ff}), .quotient(nxq));
   rci_div u_div_nz (.clock(clock), .dividend(64'(ez12_ff) <<< FRAC_BITS),
                     .divisor({1'b0, rad_ff}), .quotient(nzq));

   localparam int SIDE13_W = 2 + 6 * 32;
   logic [SIDE13_W-1:0] side13;
   logic                v13, bad13;
   logic signed [31:0]  t13, hx13, hy13, hz13, dx13, dz13;

   rci_delay #(.WIDTH(SIDE13_W), .DEPTH(DIV_LAT)) u_dly_norm (
      .clock(clock), .reset(reset),
      .din({v12_ff, bad12_ff, t12_ff, hx12_ff, hy12_ff, hz12_ff, dx12_ff, dz12_ff}),
      .dout(side13));
   assign {v13, bad13, t13, hx13, hy13, hz13, dx13, dz13} = side13;

   // stage 14: facing products
   logic               v14_ff, bad14_ff;
   logic signed [63:0] fx14_ff, fz14_ff;
   logic signed [17:0] nx14_ff, nz14_ff;
   logic signed [31:0] t14_ff, hx14_ff, hy14_ff, hz14_ff;

   always_ff @(posedge clock) begin
      if (reset) v14_ff <= 1'b0;
      else v14_ff <= v13;
      bad14_ff <= bad13;
      fx14_ff  <= 64'(dx13) * 64'($signed(nxq[17:0]));
      fz14_ff  <= 64'(dz13) * 64'($signed(nzq[17:0]));
      nx14_ff  <= nxq[17:0];
      nz14_ff  <= nzq[17:0];
      t14_ff   <= t13;
      hx14_ff  <= hx13;
      hy14_ff  <= hy13;
      hz14_ff  <= hz13;
   end

   // stage 15: response register
   logic        front;
   logic [64:0] dot;
   assign dot   = 65'(fx14_ff) + 65'(fz14_ff);
   assign front = dot[64];

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= v14_ff;
      rsp_hit        <= !bad14_ff;
      rsp_hit_t      <= bad14_ff ? '0 : t14_ff;
      rsp_hit_x      <= bad14_ff ? '0 : hx14_ff;
      rsp_hit_y      <= bad14_ff ? '0 : hy14_ff;
      rsp_hit_z      <= bad14_ff ? '0 : hz14_ff;
      rsp_normal_x   <= bad14_ff ? '0 : (front ? nx14_ff : -nx14_ff);
      rsp_normal_z   <= bad14_ff ? '0 : (front ? nz14_ff : -nz14_ff);
      rsp_front_face <= !bad14_ff && front;
   end
endmodule
`default_nettype wire

/* design/rci_checker.sv */
// port-level checks for the ray versus cylinder intersector
`default_nettype none
module rci_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire logic              rsp_hit,
   input wire logic              rsp_front_face,
   input wire rci_pkg::coord_type rsp_hit_t,
   input wire rci_pkg::norm_type rsp_normal_x,
   input wire rci_pkg::norm_type rsp_normal_z
);
   import rci_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_miss_zero_t: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_t == '0) else $error("miss with nonzero t");
   a_miss_no_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> !rsp_front_face && rsp_normal_x == '0 &&
      rsp_normal_z == '0) else $error("miss with normal");
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x >= -18'sd65536 && rsp_normal_x <= 18'sd65536)
      else $error("normal out of range");
endmodule

bind ray_cylinder_intersect rci_checker u_rci_checker (.*);
`default_nettype wire
